// File: src/sssd_pkg.sv
// Shared types, constants and the hex font of the scan shift driver.
package sssd_pkg;

	typedef struct packed {
		logic [7:0] pattern;
		logic [2:0] sel_old;
		logic [2:0] sel_new;
		logic       speaker;
	} sssd_word_t;

	typedef struct packed {
		logic push;
	} sssd_qctl_t;

	typedef enum logic [2:0] {
		PHASE_HIGH = 3'b001,
		PHASE_LOW  = 3'b010,
		PHASE_LED  = 3'b100
	} sssd_phase_t;

	localparam logic [7:0] DecRecip   = 8'd205;
	localparam logic [3:0] DecTen     = 4'd10;
	localparam logic [2:0] SelAllOff  = 3'b111;
	localparam logic [2:0] LastBitIdx = 3'd7;

	function automatic logic [7:0] font_hex(input logic [3:0] nibble);
		logic [7:0] seg;
		case (nibble)
			4'h0: seg = 8'h3f;
			4'h1: seg = 8'h06;
			4'h2: seg = 8'h5b;
			4'h3: seg = 8'h4f;
			4'h4: seg = 8'h66;
			4'h5: seg = 8'h6d;
			4'h6: seg = 8'h7d;
			4'h7: seg = 8'h07;
			4'h8: seg = 8'h7f;
			4'h9: seg = 8'h6f;
			4'ha: seg = 8'h77;
			4'hb: seg = 8'h7c;
			4'hc: seg = 8'h39;
			4'hd: seg = 8'h5e;
			4'he: seg = 8'h79;
			4'hf: seg = 8'h71;
			default: seg = 8'h3f;
		endcase
		return seg;
	endfunction

endpackage

// File: src/sssd_front.sv
// Front end: accepts scan ticks, tracks phase, select and speaker, builds the word to shift.
module sssd_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     segment_mode,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               display_value,
	input  logic                     decimal_format,
	input  logic [15:0]              segment_pattern,
	input  logic [7:0]               led_pattern,
	input  logic                     sound_on,
	output sssd_pkg::sssd_qctl_t     qctl,
	input  logic                     q_ready,
	output sssd_pkg::sssd_word_t     push_word
);
	import sssd_pkg::*;

	sssd_phase_t phase_q;
	logic [2:0]  sel_q;
	logic        speaker_q;
	logic        tone_q;

	logic [15:0] prod;
	logic [4:0]  tens;
	logic [7:0]  tens_x10;
	logic [7:0]  ones;
	logic [7:0]  digits;
	logic        accept;
	logic        speaker_next;
	logic [7:0]  pattern;
	logic [2:0]  sel_next;
	sssd_phase_t phase_next;

	assign in_ready   = q_ready;
	assign accept     = in_valid && q_ready;
	assign qctl.push  = accept;

	assign prod     = display_value * DecRecip;
	assign tens     = prod[15:11];
	assign tens_x10 = tens * DecTen;
	assign ones     = display_value - tens_x10;
	assign digits   = decimal_format ? {tens[3:0], ones[3:0]} : display_value;

	assign speaker_next = sound_on ? tone_q : speaker_q;

	always_comb begin
		case (phase_q)
			PHASE_LOW: begin
				pattern    = segment_mode ? segment_pattern[7:0] : font_hex(digits[3:0]);
				sel_next   = (sel_q | 3'b001) & 3'b101;
				phase_next = PHASE_LED;
			end
			PHASE_LED: begin
				pattern    = led_pattern;
				sel_next   = (sel_q | 3'b010) & 3'b011;
				phase_next = PHASE_HIGH;
			end
			default: begin
				pattern    = segment_mode ? segment_pattern[15:8] : font_hex(digits[7:4]);
				sel_next   = (sel_q | 3'b100) & 3'b110;
				phase_next = PHASE_LOW;
			end
		endcase
	end

	assign push_word.pattern = pattern;
	assign push_word.sel_old = sel_q;
	assign push_word.sel_new = sel_next;
	assign push_word.speaker = speaker_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PHASE_HIGH;
			sel_q     <= SelAllOff;
			speaker_q <= 1'b0;
			tone_q    <= 1'b1;
		end else if (accept) begin
			phase_q   <= phase_next;
			sel_q     <= sel_next;
			speaker_q <= speaker_next;
			if (sound_on) begin
				tone_q <= ~tone_q;
			end
		end
	end

endmodule

// File: src/sssd_queue.sv
// Two-entry queue between the front end and the shift stage.
module sssd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sssd_pkg::sssd_qctl_t qctl,
	input  sssd_pkg::sssd_word_t push_word,
	output logic                 q_ready,
	input  logic                 pop,
	output logic                 q_valid,
	output sssd_pkg::sssd_word_t pop_word,
	output logic [1:0]           q_count
);
	import sssd_pkg::*;

	sssd_word_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign q_ready  = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign do_push  = qctl.push && q_ready;
	assign do_pop   = pop && q_valid;
	assign pop_word = mem_q[rd_ptr_q];
	assign q_count  = count_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/sssd_back.sv
// Shift stage: sends each word MSB first, one bit per result, latch on the eighth.
module sssd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  sssd_pkg::sssd_word_t pop_word,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 serial_data,
	output logic                 latch_strobe,
	output logic [2:0]           select_lines,
	output logic                 speaker_level,
	output logic                 last_bit
);
	import sssd_pkg::*;

	logic       busy_q;
	logic [2:0] cnt_q;
	logic [7:0] shift_q;
	logic [2:0] sel_old_q;
	logic [2:0] sel_new_q;
	logic       speaker_q;
	logic       is_last;
	logic       finish;

	assign is_last = (cnt_q == LastBitIdx);
	assign finish  = busy_q && out_ready && is_last;
	assign pop     = q_valid && (!busy_q || finish);

	assign out_valid     = busy_q;
	assign serial_data   = shift_q[7];
	assign latch_strobe  = is_last;
	assign last_bit      = is_last;
	assign select_lines  = is_last ? sel_new_q : sel_old_q;
	assign speaker_level = speaker_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			shift_q   <= pop_word.pattern;
			sel_old_q <= pop_word.sel_old;
			sel_new_q <= pop_word.sel_new;
			speaker_q <= pop_word.speaker;
		end else if (busy_q && out_ready) begin
			shift_q <= {shift_q[6:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else if (pop) begin
			busy_q <= 1'b1;
			cnt_q  <= 3'd0;
		end else if (finish) begin
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else if (busy_q && out_ready) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

endmodule

// File: src/seven_segment_scan_shift_driver_unit.sv
// Top level of the seven-segment scan shift driver.
// A tick accepted into an empty block is written into the queue, then loaded into the shift stage.
// The shift stage sends one bit per cycle while out_ready is high;
// a two-word queue lets the front accept ticks while the shift stage is busy.
// Reset: phase to the high digit, selects all off, speaker low, tone toggle high, queue empty.
module seven_segment_scan_shift_driver_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic        cfg_write_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  display_value,
	input  logic        decimal_format,
	input  logic [15:0] segment_pattern,
	input  logic [7:0]  led_pattern,
	input  logic        sound_on,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        serial_data,
	output logic        latch_strobe,
	output logic [2:0]  select_lines,
	output logic        speaker_level,
	output logic        last_bit
);
	import sssd_pkg::*;

	logic       segment_mode_q;
	sssd_qctl_t qctl;
	sssd_word_t push_word;
	sssd_word_t pop_word;
	logic       q_ready;
	logic       q_valid;
	logic       pop;
	logic [1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_mode_q <= 1'b0;
		end else if (cfg_write_en) begin
			segment_mode_q <= cfg_write_data;
		end
	end

	sssd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.segment_mode    (segment_mode_q),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.display_value   (display_value),
		.decimal_format  (decimal_format),
		.segment_pattern (segment_pattern),
		.led_pattern     (led_pattern),
		.sound_on        (sound_on),
		.qctl            (qctl),
		.q_ready         (q_ready),
		.push_word       (push_word)
	);

	sssd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.qctl      (qctl),
		.push_word (push_word),
		.q_ready   (q_ready),
		.pop       (pop),
		.q_valid   (q_valid),
		.pop_word  (pop_word),
		.q_count   (q_count)
	);

	sssd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.pop_word      (pop_word),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.serial_data   (serial_data),
		.latch_strobe  (latch_strobe),
		.select_lines  (select_lines),
		.speaker_level (speaker_level),
		.last_bit      (last_bit)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count != 2'd3)
		else $error("queue count out of range");

	a_byte_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_bit |=> out_valid)
		else $error("word dropped before its last bit");

	a_one_select_on: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_bit |-> $countones(select_lines) == 2)
		else $error("latched select does not enable exactly one line");

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_count == 2'd2 |-> !in_ready)
		else $error("front ready while queue full");

endmodule

// File: tb/seven_segment_scan_shift_driver_unit_tb.sv
// Testbench for the seven-segment scan shift driver: directed table, random ticks, bit checks.
module seven_segment_scan_shift_driver_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sssd_pkg::*;

	localparam bit MODE_DIGITS = 1'b0;
	localparam bit MODE_RAW    = 1'b1;
	localparam int RANDOM_PHASES = 6;
	localparam int TICKS_PER_PHASE = 80;

	localparam logic [7:0] SEG_FONT [16] = '{
		8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
		8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
	};

	typedef struct packed {
		logic        mode;
		logic [7:0]  display_value;
		logic        decimal_format;
		logic [15:0] segment_pattern;
		logic [7:0]  led_pattern;
		logic        sound_on;
		logic        typed;
		logic [7:0]  glyph_exp;
	} tick_row_t;

	typedef struct packed {
		logic       data;
		logic       strobe;
		logic [2:0] sel;
		logic       spk;
		logic       last;
	} bit_result_t;

	localparam int SCRIPT_LEN = 21;
	localparam tick_row_t SCRIPT [SCRIPT_LEN] = '{
		'{MODE_DIGITS, 8'h00, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b1, 8'h3f},
		'{MODE_DIGITS, 8'hff, 1'b0, 16'hffff, 8'h00, 1'b1, 1'b1, 8'h71},
		'{MODE_DIGITS, 8'h00, 1'b0, 16'h0000, 8'hff, 1'b1, 1'b1, 8'hff},
		'{MODE_DIGITS, 8'hff, 1'b1, 16'h0000, 8'h00, 1'b1, 1'b1, 8'h6f},
		'{MODE_DIGITS, 8'hff, 1'b1, 16'h0000, 8'h00, 1'b0, 1'b1, 8'h6d},
		'{MODE_DIGITS, 8'h00, 1'b0, 16'h0000, 8'h00, 1'b1, 1'b1, 8'h00},
		'{MODE_DIGITS, 8'd160, 1'b1, 16'h0000, 8'h00, 1'b0, 1'b1, 8'h3f},
		'{MODE_DIGITS, 8'd99, 1'b1, 16'h0000, 8'h00, 1'b0, 1'b1, 8'h6f},
		'{MODE_DIGITS, 8'h5a, 1'b0, 16'h0000, 8'ha5, 1'b0, 1'b0, 8'h00},
		'{MODE_DIGITS, 8'hab, 1'b0, 16'h0000, 8'h00, 1'b1, 1'b0, 8'h00},
		'{MODE_DIGITS, 8'hcd, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0, 8'h00},
		'{MODE_DIGITS, 8'he0, 1'b0, 16'h0000, 8'h3c, 1'b1, 1'b0, 8'h00},
		'{MODE_RAW, 8'h00, 1'b0, 16'hffff, 8'h00, 1'b1, 1'b1, 8'hff},
		'{MODE_RAW, 8'hff, 1'b1, 16'h0000, 8'hff, 1'b0, 1'b1, 8'h00},
		'{MODE_RAW, 8'h00, 1'b0, 16'h0000, 8'h5a, 1'b1, 1'b0, 8'h00},
		'{MODE_RAW, 8'h00, 1'b0, 16'h1234, 8'h00, 1'b0, 1'b1, 8'h12},
		'{MODE_RAW, 8'h00, 1'b0, 16'h1234, 8'h00, 1'b1, 1'b1, 8'h34},
		'{MODE_RAW, 8'h00, 1'b0, 16'h0000, 8'h81, 1'b1, 1'b1, 8'h81},
		'{MODE_DIGITS, 8'h7e, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0, 8'h00},
		'{MODE_DIGITS, 8'd42, 1'b1, 16'h0000, 8'h00, 1'b1, 1'b0, 8'h00},
		'{MODE_DIGITS, 8'h00, 1'b0, 16'h0000, 8'h00, 1'b1, 1'b0, 8'h00}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic        cfg_write_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  display_value = '0;
	logic        decimal_format = 1'b0;
	logic [15:0] segment_pattern = '0;
	logic [7:0]  led_pattern = '0;
	logic        sound_on = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        serial_data;
	logic        latch_strobe;
	logic [2:0]  select_lines;
	logic        speaker_level;
	logic        last_bit;

	bit          steady = 1'b0;
	int          errors = 0;
	int          stall_left = 0;
	bit_result_t pending_bits [$];

	logic        mode_q = MODE_DIGITS;
	sssd_phase_t phase_q = PHASE_HIGH;
	logic [2:0]  sel_q = SelAllOff;
	logic        spk_q = 1'b0;
	logic        tone_q = 1'b1;

	seven_segment_scan_shift_driver_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.display_value(display_value),
		.decimal_format(decimal_format),
		.segment_pattern(segment_pattern),
		.led_pattern(led_pattern),
		.sound_on(sound_on),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.serial_data(serial_data),
		.latch_strobe(latch_strobe),
		.select_lines(select_lines),
		.speaker_level(speaker_level),
		.last_bit(last_bit)
	);

	always #2 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic void predict_tick(input tick_row_t t);
		logic [7:0] tens;
		logic [7:0] ones;
		logic [7:0] digits;
		logic [7:0] glyph;
		logic [2:0] prev_sel;
		if (t.sound_on) begin
			spk_q = tone_q;
			tone_q = ~tone_q;
		end
		tens = t.display_value / 8'd10;
		ones = t.display_value % 8'd10;
		digits = t.decimal_format ? {tens[3:0], ones[3:0]} : t.display_value;
		prev_sel = sel_q;
		case (phase_q)
			PHASE_LOW: begin
				glyph = mode_q ? t.segment_pattern[7:0] : SEG_FONT[digits[3:0]];
				sel_q = (prev_sel | 3'b001) & 3'b101;
				phase_q = PHASE_LED;
			end
			PHASE_LED: begin
				glyph = t.led_pattern;
				sel_q = (prev_sel | 3'b010) & 3'b011;
				phase_q = PHASE_HIGH;
			end
			default: begin
				glyph = mode_q ? t.segment_pattern[15:8] : SEG_FONT[digits[7:4]];
				sel_q = (prev_sel | 3'b100) & 3'b110;
				phase_q = PHASE_LOW;
			end
		endcase
		if (t.typed)
			glyph = t.glyph_exp;
		for (int i = 7; i >= 0; i--)
			pending_bits.push_back('{glyph[i], i == 0, (i == 0) ? sel_q : prev_sel,
				spk_q, i == 0});
	endfunction

	function automatic tick_row_t rand_tick();
		tick_row_t t;
		t.mode = mode_q;
		t.display_value = 8'($urandom_range(0, 255));
		t.decimal_format = 1'($urandom_range(0, 1));
		t.segment_pattern = 16'($urandom_range(0, 65535));
		t.led_pattern = 8'($urandom_range(0, 255));
		t.sound_on = 1'($urandom_range(0, 1));
		t.typed = 1'b0;
		t.glyph_exp = '0;
		return t;
	endfunction

	task automatic put_tick(input tick_row_t t);
		int gap;
		gap = steady ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		display_value <= t.display_value;
		decimal_format <= t.decimal_format;
		segment_pattern <= t.segment_pattern;
		led_pattern <= t.led_pattern;
		sound_on <= t.sound_on;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_tick(t);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_bits.size() != 0) @(posedge clk);
	endtask

	task automatic set_mode(input logic m);
		cfg_write_en <= 1'b1;
		cfg_write_data <= m;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		mode_q = m;
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!steady)
				stall_left <= gap_len();
		end
	end

	always @(posedge clk) begin : watch
		bit_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_bits.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				want = pending_bits.pop_front();
				if (serial_data !== want.data) begin
					$error("serial_data expected %0b got %0b", want.data, serial_data);
					errors++;
				end
				if (latch_strobe !== want.strobe) begin
					$error("latch_strobe expected %0b got %0b", want.strobe, latch_strobe);
					errors++;
				end
				if (select_lines !== want.sel) begin
					$error("select_lines expected %0b got %0b", want.sel, select_lines);
					errors++;
				end
				if (speaker_level !== want.spk) begin
					$error("speaker_level expected %0b got %0b", want.spk, speaker_level);
					errors++;
				end
				if (last_bit !== want.last) begin
					$error("last_bit expected %0b got %0b", want.last, last_bit);
					errors++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("[seven_segment_scan_shift_driver_unit] ERROR");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int r = 0; r < SCRIPT_LEN; r++) begin
			if (SCRIPT[r].mode != mode_q) begin
				drain();
				set_mode(SCRIPT[r].mode);
			end
			put_tick(SCRIPT[r]);
		end
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			set_mode((p % 2 == 0) ? MODE_RAW : MODE_DIGITS);
			steady = (p == 2);
			for (int k = 0; k < TICKS_PER_PHASE; k++) begin
				// hold off the sender until the pipe runs empty
				if (p == 3 && k == TICKS_PER_PHASE / 2)
					drain();
				put_tick(rand_tick());
			end
		end
		steady = 1'b0;
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("[seven_segment_scan_shift_driver_unit] OK");
		else
			$display("[seven_segment_scan_shift_driver_unit] ERROR");
		$finish;
	end

endmodule

// File: files.f
src/sssd_pkg.sv
src/sssd_front.sv
src/sssd_queue.sv
src/sssd_back.sv
src/seven_segment_scan_shift_driver_unit.sv
tb/seven_segment_scan_shift_driver_unit_tb.sv
